### hdl/u16u8_pkg.sv
// Shared types, constants and helpers for the UTF-16 to UTF-8 converter.
`default_nettype none

package u16u8_pkg;

    localparam int QueueDepth = 4;
    localparam int CapW       = 16;
    localparam int CountW     = 17;
    localparam int PointW     = 21;
    localparam int UnitW      = 16;
    localparam int AddrW      = 3;

    // Register 0 is the strict-mode flag, register 1 the output capacity.
    localparam logic RegStrict   = 1'b0;
    localparam logic RegCapacity = 1'b1;

    localparam logic [CapW-1:0] CapacityReset = 16'd256;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_SRC_EXHAUSTED = 2'd1,
        ST_TGT_EXHAUSTED = 2'd2,
        ST_SRC_ILLEGAL   = 2'd3
    } t_status;

    // One queue entry: up to two code points to encode, or a terminator status.
    typedef struct packed {
        logic              term;
        t_status           status;
        logic [2:0]        len_a;
        logic [PointW-1:0] cp_a;
        logic [2:0]        len_b;
        logic [UnitW-1:0]  cp_b;
    } t_job;

    function automatic logic [7:0] lead_mark(input logic [2:0] len);
        logic [7:0] mark;
        case (len)
            3'd2:    mark = 8'hC0;
            3'd3:    mark = 8'hE0;
            3'd4:    mark = 8'hF0;
            default: mark = 8'h00;
        endcase
        return mark;
    endfunction

endpackage

`default_nettype wire

### hdl/u16u8_ifs.sv
// Valid/ready channel interfaces for code units in and result words out.
`default_nettype none

interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink (input valid, input code_unit, output ready);
    modport monitor (input valid, input code_unit, input ready);
endinterface

interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       finished;
    logic [1:0] status;

    modport source (output valid, output out_byte, output has_byte, output last_of_run,
                    output finished, output status, input ready);
    modport sink (input valid, input out_byte, input has_byte, input last_of_run,
                  input finished, input status, output ready);
    modport monitor (input valid, input out_byte, input has_byte, input last_of_run,
                     input finished, input status, input ready);
endinterface

`default_nettype wire

### hdl/utf16_to_utf8_converter.sv
// Top level of the UTF-16 to UTF-8 converter with its register port.
//
// Code units enter one per cycle as long as the job queue has room; a unit
// that ends the string, or that yields bytes, places one job in the queue,
// and the serializer drains jobs at one result word per cycle while the
// output is not stalled. A unit yields one status word when it ends the
// string, one to three bytes for a BMP character, four for a surrogate pair
// and up to six when a lenient unpaired high surrogate precedes a character.
// Units that yield nothing place no job. The output register is the only
// limit on throughput; QUEUE_DEPTH jobs can wait while the output stalls.
// Registers: word 0 holds strict_mode (bit 0), word 1 out_capacity
// (bits 15:0); change them only while no string is in flight.
`default_nettype none

module utf16_to_utf8_converter #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QueueDepth
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    u16u8_in_if.sink                         i_unit,
    u16u8_out_if.source                      o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [u16u8_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import u16u8_pkg::*;

    logic            r_strict;
    logic [CapW-1:0] r_cap;
    logic            wr_en;
    logic            push, full, pop, empty;
    t_job            job, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Byte offsets inside a word select that word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
            r_cap    <= CapacityReset;
        end else if (wr_en) begin
            if (paddr[2] == RegStrict) begin
                r_strict <= pwdata[0];
            end else begin
                r_cap <= pwdata[CapW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == RegCapacity) begin
            prdata = {16'b0, r_cap};
        end else begin
            prdata = {31'b0, r_strict};
        end
    end

    u16u8_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_unit         (i_unit),
        .i_strict_mode  (r_strict),
        .i_out_capacity (r_cap),
        .i_q_full       (full),
        .o_push         (push),
        .o_job          (job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### hdl/u16u8_front.sv
// Front end: takes code units, tracks surrogates, byte count and errors, queues work.
`default_nettype none

module u16u8_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    u16u8_in_if.sink                        i_unit,
    input  wire logic                       i_strict_mode,
    input  wire logic [u16u8_pkg::CapW-1:0] i_out_capacity,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output u16u8_pkg::t_job                 o_job
);
    import u16u8_pkg::*;

    logic              r_pend;
    logic [9:0]        r_hi;
    logic [CountW-1:0] r_bw;
    t_status           r_err;

    logic              n_pend;
    logic [9:0]        n_hi;
    logic [CountW-1:0] n_bw;
    t_status           n_err;

    logic              acc;
    logic [UnitW-1:0]  u;
    logic              is_zero, is_high, is_low, ok;
    logic [PointW-1:0] cp_a;
    logic [2:0]        len_a, len_b;
    logic [CountW:0]   bw_a, bw_b;
    logic [CountW-1:0] bw_b_base;
    logic              do_a, fit_a, emit_a, cont_b, enc_b, fit_b, emit_b;

    assign i_unit.ready = !i_q_full;
    assign acc = i_unit.valid && !i_q_full;
    assign u = i_unit.code_unit;

    always_comb begin
        is_zero = (u == '0);
        is_high = (u[15:10] == 6'b110110);
        is_low  = (u[15:10] == 6'b110111);
        ok      = (r_err == ST_OK);

        // Slot A carries the held high surrogate: joined with a low one, or alone.
        if (is_low) begin
            cp_a  = 21'h10000 + 21'({r_hi, u[9:0]});
            len_a = 3'd4;
        end else begin
            cp_a  = {5'b0, 6'b110110, r_hi};
            len_a = 3'd3;
        end
        bw_a   = 18'(r_bw) + 18'(len_a);
        fit_a  = (bw_a <= 18'(i_out_capacity));
        do_a   = !is_zero && ok && r_pend && (is_low || !i_strict_mode);
        emit_a = do_a && fit_a;

        // Slot B carries the unit itself when it is processed on its own.
        cont_b = !is_zero && ok &&
                 (!r_pend || (!is_low && !i_strict_mode && fit_a));
        if (u[15:7] == '0) begin
            len_b = 3'd1;
        end else if (u[15:11] == '0) begin
            len_b = 3'd2;
        end else begin
            len_b = 3'd3;
        end
        bw_b_base = emit_a ? bw_a[CountW-1:0] : r_bw;
        bw_b      = 18'(bw_b_base) + 18'(len_b);
        fit_b     = (bw_b <= 18'(i_out_capacity));
        enc_b     = cont_b && !is_high && !(is_low && i_strict_mode);
        emit_b    = enc_b && fit_b;

        n_pend = r_pend;
        n_hi   = r_hi;
        n_bw   = r_bw;
        n_err  = r_err;
        if (acc) begin
            if (is_zero) begin
                n_pend = 1'b0;
                n_hi   = '0;
                n_bw   = '0;
                n_err  = ST_OK;
            end else if (ok) begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    n_hi   = '0;
                end
                if (r_pend && !is_low && i_strict_mode) begin
                    n_err = ST_SRC_ILLEGAL;
                end
                if (do_a && !fit_a) begin
                    n_err = ST_TGT_EXHAUSTED;
                end
                if (cont_b) begin
                    if (is_high) begin
                        n_pend = 1'b1;
                        n_hi   = u[9:0];
                    end else if (is_low && i_strict_mode) begin
                        n_err = ST_SRC_ILLEGAL;
                    end else if (!fit_b) begin
                        n_err = ST_TGT_EXHAUSTED;
                    end
                end
                n_bw = emit_b ? bw_b[CountW-1:0] : bw_b_base;
            end
        end

        o_job.term   = is_zero;
        o_job.status = !ok ? r_err : (r_pend ? ST_SRC_EXHAUSTED : ST_OK);
        o_job.len_a  = emit_a ? len_a : 3'd0;
        o_job.cp_a   = cp_a;
        o_job.len_b  = emit_b ? len_b : 3'd0;
        o_job.cp_b   = u;
        o_push       = acc && (is_zero || emit_a || emit_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hi   <= '0;
            r_bw   <= '0;
            r_err  <= ST_OK;
        end else begin
            r_pend <= n_pend;
            r_hi   <= n_hi;
            r_bw   <= n_bw;
            r_err  <= n_err;
        end
    end

endmodule

`default_nettype wire

### hdl/u16u8_queue.sv
// Small job queue between the front end and the byte serializer.
`default_nettype none

module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QueueDepth
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire u16u8_pkg::t_job i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output u16u8_pkg::t_job      o_head
);
    import u16u8_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastPtr) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastPtr) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/u16u8_back.sv
// Back end: turns queued jobs into UTF-8 bytes and status words, one per cycle unless the output stalls.
`default_nettype none

module u16u8_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire u16u8_pkg::t_job i_head,
    output logic                 o_pop,
    u16u8_out_if.source          o_result
);
    import u16u8_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has, r_last, r_fin;
    t_status    r_status;
    logic       r_phase;
    logic [1:0] r_idx;

    logic              load, sel_b, end_part, last;
    logic [2:0]        cur_len, sh_w;
    logic [PointW-1:0] cur_cp, seg;
    logic [7:0]        byte_val;

    assign load = !i_empty && (!r_valid || o_result.ready);

    always_comb begin
        sel_b    = r_phase || (i_head.len_a == 3'd0);
        cur_len  = sel_b ? i_head.len_b : i_head.len_a;
        cur_cp   = sel_b ? PointW'(i_head.cp_b) : i_head.cp_a;
        end_part = ({1'b0, r_idx} == cur_len - 3'd1);
        sh_w     = cur_len - 3'd1 - {1'b0, r_idx};
        case (sh_w[1:0])
            2'd0:    seg = cur_cp;
            2'd1:    seg = cur_cp >> 6;
            2'd2:    seg = cur_cp >> 12;
            2'd3:    seg = cur_cp >> 18;
            default: seg = cur_cp;
        endcase
        if (r_idx == 2'd0) begin
            byte_val = seg[7:0] | lead_mark(cur_len);
        end else begin
            byte_val = {2'b10, seg[5:0]};
        end
        last  = i_head.term || (end_part && (sel_b || i_head.len_b == 3'd0));
        o_pop = load && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (last) begin
                    r_phase <= 1'b0;
                    r_idx   <= '0;
                end else if (end_part) begin
                    r_phase <= 1'b1;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= i_head.term ? 8'h00 : byte_val;
            r_has    <= !i_head.term;
            r_last   <= last;
            r_fin    <= i_head.term;
            r_status <= i_head.term ? i_head.status : ST_OK;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.out_byte    = r_byte;
    assign o_result.has_byte    = r_has;
    assign o_result.last_of_run = r_last;
    assign o_result.finished    = r_fin;
    assign o_result.status      = r_status;

endmodule

`default_nettype wire

### hdl/u16u8_checker.sv
// Port-level checks on the converter's result channel, bound to the top level.
`default_nettype none

module u16u8_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_has_byte,
    input wire logic       i_last_of_run,
    input wire logic       i_finished,
    input wire logic [1:0] i_status
);
    import u16u8_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            i_valid && $stable(i_out_byte) && $stable(i_finished))
        else $error("result word changed while stalled");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_finished |->
            i_last_of_run && !i_has_byte && i_out_byte == 8'h00)
        else $error("status word is malformed");

    a_byte_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_byte |->
            i_status == ST_OK && !i_finished)
        else $error("byte word carries a status");

    a_no_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_byte |-> i_finished)
        else $error("word without byte is not a status word");

endmodule

bind utf16_to_utf8_converter u16u8_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_result.valid),
    .i_ready       (o_result.ready),
    .i_out_byte    (o_result.out_byte),
    .i_has_byte    (o_result.has_byte),
    .i_last_of_run (o_result.last_of_run),
    .i_finished    (o_result.finished),
    .i_status      (o_result.status)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the UTF-16 to UTF-8 converter, with its expected-word tracker.
import u16u8_pkg::*;

localparam logic [AddrW-1:0] StrictAddr   = AddrW'(RegStrict) << 2;
localparam logic [AddrW-1:0] CapacityAddr = AddrW'(RegCapacity) << 2;

localparam logic [15:0] EndOfString = 16'h0000;
localparam logic [15:0] HighFirst   = 16'hD800;
localparam logic [15:0] HighLast    = 16'hDBFF;
localparam logic [15:0] LowFirst    = 16'hDC00;
localparam logic [15:0] LowLast     = 16'hDFFF;

typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       finished;
    t_status    status;
} utf8_word_t;

class utf8_tracker;
    bit         strict_on = 1'b1;
    bit [15:0]  capacity = CapacityReset;
    bit [9:0]   held_high;
    bit         held_valid;
    bit [16:0]  written;
    t_status    stop_status = ST_OK;
    bit [7:0]   lead_bits [5] = '{8'h00, 8'h00, 8'hC0, 8'hE0, 8'hF0};
    utf8_word_t words_due [$];
    utf8_word_t unit_words [$];
    int         failures;

    function void set_reg(logic [AddrW-1:0] addr, logic [31:0] data);
        if (addr == StrictAddr) strict_on = data[0];
        else if (addr == CapacityAddr) capacity = data[15:0];
    endfunction

    function void push_word(bit [7:0] b, bit has, bit fin, t_status st);
        unit_words.push_back('{b, has, 1'b0, fin, st});
    endfunction

    // Returns 0 when the code point does not fit in what is left of the capacity.
    function bit encode_point(int unsigned cp);
        int unsigned len;
        int unsigned v;
        bit [7:0]    bytes_out [4];
        len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        if (written + len > capacity) begin
            stop_status = ST_TGT_EXHAUSTED;
            return 1'b0;
        end
        v = cp;
        for (int i = len - 1; i > 0; i--) begin
            bytes_out[i] = 8'h80 | 8'(v & 'h3F);
            v = v >> 6;
        end
        bytes_out[0] = 8'(v) | lead_bits[len];
        for (int i = 0; i < len; i++) push_word(bytes_out[i], 1'b1, 1'b0, ST_OK);
        written = written + 17'(len);
        return 1'b1;
    endfunction

    function void plain_unit(bit [15:0] u);
        if (u >= HighFirst && u <= HighLast) begin
            held_high  = 10'(u - HighFirst);
            held_valid = 1'b1;
        end else if (u >= LowFirst && u <= LowLast && strict_on) begin
            stop_status = ST_SRC_ILLEGAL;
        end else begin
            void'(encode_point(u));
        end
    endfunction

    function void take_unit(bit [15:0] u);
        t_status     st;
        int unsigned hi;
        unit_words.delete();
        if (u == EndOfString) begin
            st = stop_status;
            if (st == ST_OK && held_valid) st = ST_SRC_EXHAUSTED;
            push_word(8'h00, 1'b0, 1'b1, st);
            held_high   = '0;
            held_valid  = 1'b0;
            written     = '0;
            stop_status = ST_OK;
        end else if (stop_status == ST_OK) begin
            if (held_valid) begin
                hi         = held_high;
                held_valid = 1'b0;
                held_high  = '0;
                if (u >= LowFirst && u <= LowLast)
                    void'(encode_point('h10000 + (hi << 10) + (u - LowFirst)));
                else if (strict_on)
                    stop_status = ST_SRC_ILLEGAL;
                else if (encode_point(HighFirst + hi))
                    plain_unit(u);
            end else begin
                plain_unit(u);
            end
        end
        if (unit_words.size() > 0) unit_words[unit_words.size() - 1].last_of_run = 1'b1;
        foreach (unit_words[i]) words_due.push_back(unit_words[i]);
    endfunction

    function void check_word(utf8_word_t seen);
        utf8_word_t want;
        if (words_due.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected word: byte %h has %b last %b fin %b status %0d",
                         seen.out_byte, seen.has_byte, seen.last_of_run, seen.finished,
                         seen.status);
            return;
        end
        want = words_due.pop_front();
        if (seen !== want) begin
            failures++;
            if (failures <= 10)
                $display("word error: got byte %h has %b last %b fin %b status %0d, %s",
                         seen.out_byte, seen.has_byte, seen.last_of_run, seen.finished,
                         seen.status,
                         $sformatf("wanted byte %h has %b last %b fin %b status %0d",
                                   want.out_byte, want.has_byte, want.last_of_run,
                                   want.finished, want.status));
        end
    endfunction
endclass

module testbench;

    localparam int IdleLimit    = 5000;
    localparam int SettleCycles = 20;
    localparam int PhaseUnits   = 24;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int units_sent;
    int idle_cycles;

    utf8_tracker tracker = new;

    u16u8_in_if  unit_ch ();
    u16u8_out_if result_ch ();

    utf16_to_utf8_converter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_unit   (unit_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The long hold-off is counted down here, one cycle per falling edge.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            result_ch.ready <= 1'b0;
            hold_cycles     <= hold_cycles - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        utf8_word_t seen;
        if (i_rst_n) begin
            if (unit_ch.valid && unit_ch.ready) tracker.take_unit(unit_ch.code_unit);
            if (result_ch.valid && result_ch.ready) begin
                seen = '{result_ch.out_byte, result_ch.has_byte, result_ch.last_of_run,
                         result_ch.finished, t_status'(result_ch.status)};
                tracker.check_word(seen);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((unit_ch.valid && unit_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IdleLimit) begin
            $display("utf16_to_utf8_converter: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_unit(input logic [15:0] unit);
        while ($urandom_range(99) < send_idle_pct) begin
            unit_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        unit_ch.valid     <= 1'b1;
        unit_ch.code_unit <= unit;
        @(posedge i_clk);
        while (!unit_ch.ready) @(posedge i_clk);
        units_sent++;
        @(negedge i_clk);
    endtask

    // Mostly well-formed text with random content, plus some lone surrogates and stray units.
    task automatic send_random_string(input int max_points);
        int          points;
        logic [15:0] u;
        points = $urandom_range(max_points, 0);
        repeat (points) begin
            case ($urandom_range(9))
                0, 1, 2: send_unit(16'($urandom_range(16'h007F, 16'h0001)));
                3, 4:    send_unit(16'($urandom_range(16'h07FF, 16'h0080)));
                5: begin
                    u = 16'($urandom_range(16'hFFFF, 16'h0800));
                    if (u >= HighFirst && u <= LowLast) u = u ^ 16'h2000;
                    send_unit(u);
                end
                6, 7: begin
                    send_unit(16'($urandom_range(HighLast, HighFirst)));
                    send_unit(16'($urandom_range(LowLast, LowFirst)));
                end
                8:       send_unit(16'($urandom_range(LowLast, HighFirst)));
                default: send_unit(16'($urandom_range(16'hFFFF)));
            endcase
        end
        send_unit(EndOfString);
    endtask

    task automatic send_random_phase();
        int start;
        start = units_sent;
        while (units_sent - start < PhaseUnits) send_random_string(6);
    endtask

    task automatic wait_drain();
        unit_ch.valid <= 1'b0;
        while (tracker.words_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_reg(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        unit_ch.valid     = 1'b0;
        unit_ch.code_unit = '0;
        result_ch.ready   = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_cycles       = 0;
        units_sent        = 0;
        idle_cycles       = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register reset values: strict, capacity 256. Length boundaries and surrogate pairs.
        send_unit(16'h007F);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hFFFF);
        send_unit(HighFirst);
        send_unit(LowFirst);
        send_unit(HighLast);
        send_unit(LowLast);
        send_unit(EndOfString);
        // Strict: a lone low surrogate stops the string, the next unit is dropped.
        send_unit(LowFirst);
        send_unit(16'h0041);
        send_unit(EndOfString);
        // A high surrogate right before the end of the string.
        send_unit(HighFirst);
        send_unit(EndOfString);
        wait_drain();

        // Lenient: unpaired surrogates are encoded as three bytes each, except a high one left at the end of a string.
        write_reg(StrictAddr, 32'd0);
        write_reg(CapacityAddr, 32'hFFFF);
        send_unit(HighLast);
        send_unit(16'h0800);
        send_unit(LowFirst);
        send_unit(HighFirst);
        send_unit(16'hD801);
        send_unit(EndOfString);
        wait_drain();

        // Capacity overrun, then a capacity of zero.
        write_reg(CapacityAddr, 32'd4);
        send_unit(16'h0041);
        send_unit(16'h0800);
        send_unit(16'h0042);
        send_unit(EndOfString);
        wait_drain();
        write_reg(CapacityAddr, 32'd0);
        send_unit(16'h0041);
        send_unit(EndOfString);
        wait_drain();

        write_reg(StrictAddr, 32'd1);
        write_reg(CapacityAddr, 32'hFFFF);
        send_random_phase();
        wait_drain();

        send_idle_pct = 80;
        write_reg(StrictAddr, 32'd0);
        write_reg(CapacityAddr, 32'($urandom_range(40, 8)));
        send_random_phase();
        wait_drain();

        send_idle_pct = 0;
        stall_pct     = 80;
        write_reg(StrictAddr, 32'd1);
        write_reg(CapacityAddr, 32'($urandom_range(30, 1)));
        send_random_phase();
        wait_drain();

        // Upper data bits are junk here; only the register's own bits count.
        send_idle_pct = 20;
        stall_pct     = 20;
        write_reg(StrictAddr, {31'($urandom), 1'b0});
        write_reg(CapacityAddr, {16'($urandom), 16'hFFFF});
        send_random_phase();
        wait_drain();

        // The output side holds off for a long stretch so the input backs up.
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(StrictAddr, 32'd1);
        write_reg(CapacityAddr, 32'd256);
        @(posedge i_clk);
        hold_cycles = 300;
        @(negedge i_clk);
        repeat (4) send_random_string(8);
        wait_drain();

        if (tracker.failures == 0) $display("utf16_to_utf8_converter: match");
        else $display("utf16_to_utf8_converter: mismatch");
        $finish;
    end

endmodule
